// ----- rtl/core/rpr_pkg.sv -----
// Shared types and constants for the raster pixel resampler.
`timescale 1ns / 1ps

package rpr_pkg;

   localparam int COORD_W     = 16;     // src/dest coordinate field width
   localparam int PIX_W       = 8;      // pixel field width on the ports
   localparam int DEST_W      = 32;     // destination address width
   localparam int STORE_DEPTH = 65536;  // source raster entries
   localparam int STORE_AW    = 16;     // store address width
   localparam int CFG_DIM_W   = 9;      // source_cols / source_rows width
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DEPTH   = 8;      // result queue entries, power of two
   localparam int CORNERS     = 4;      // p00, p10, p01, p11

   localparam logic MODE_LOAD       = 1'b0;
   localparam logic MODE_SAMPLE     = 1'b1;
   localparam logic METHOD_NEAREST  = 1'b0;
   localparam logic METHOD_BILINEAR = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_METHOD      = 2'd0,
      CSR_SOURCE_COLS = 2'd1,
      CSR_SOURCE_ROWS = 2'd2,
      CSR_DEST_COLS   = 2'd3
   } rpr_csr_index_type;

   typedef struct packed {
      logic               mode;
      logic [15:0]        load_addr;
      logic [PIX_W-1:0]   load_value;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
   } rpr_req_type;

   typedef struct packed {
      logic [DEST_W-1:0] dest_addr;
      logic [PIX_W-1:0]  pixel_value;
   } rpr_rsp_type;

   typedef struct packed {
      logic                 method;
      logic [CFG_DIM_W-1:0] source_cols;
      logic [CFG_DIM_W-1:0] source_rows;
      logic [COORD_W-1:0]   dest_cols;
   } rpr_cfg_type;

   typedef struct packed {
      logic valid;
      logic sample;
   } rpr_ctl_type;

   localparam rpr_cfg_type CFG_RESET = '{
      method:      METHOD_BILINEAR,
      source_cols: 9'd256,
      source_rows: 9'd256,
      dest_cols:   16'd256
   };

endpackage

// ----- rtl/core/rpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rpr_fetch.sv -----
// Coordinate split, edge clamping, corner addresses, weights, destination address and store writes.
`timescale 1ns / 1ps

module rpr_fetch #(
   parameter int MAX_COLS  = 256,
   parameter int MAX_ROWS  = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_fire,
   input  rpr_pkg::rpr_req_type                              req_item,
   input  rpr_pkg::rpr_cfg_type                              cfg,
   output rpr_pkg::rpr_ctl_type                              s2_ctl,
   output logic [rpr_pkg::CORNERS-1:0][2*FRAC_BITS+1:0]      weight,
   output logic [rpr_pkg::DEST_W-1:0]                        dest_addr,
   output logic                                              wr_en,
   output logic [rpr_pkg::STORE_AW-1:0]                      wr_addr,
   output logic [rpr_pkg::PIX_W-1:0]                         wr_data,
   output logic [rpr_pkg::CORNERS-1:0][rpr_pkg::STORE_AW-1:0] rd_addr
);

   localparam int IW  = rpr_pkg::COORD_W - FRAC_BITS;
   localparam int CW  = $clog2(MAX_COLS + 1);
   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int XW  = $clog2(MAX_COLS);
   localparam int YW  = $clog2(MAX_ROWS);
   localparam int DCW = (CW > rpr_pkg::CFG_DIM_W) ? CW : rpr_pkg::CFG_DIM_W;
   localparam int DRW = (RW > rpr_pkg::CFG_DIM_W) ? RW : rpr_pkg::CFG_DIM_W;
   localparam int KCW = (IW + 1 > CW) ? IW + 1 : CW;
   localparam int KRW = (IW + 1 > RW) ? IW + 1 : RW;
   localparam int PW  = YW + CW;
   localparam int SW  = ((PW > XW) ? PW : XW) + 1;
   localparam int WW  = 2 * FRAC_BITS + 2;
   localparam logic [FRAC_BITS:0] ONE_UNIT = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   logic [CW-1:0] cols;
   logic [RW-1:0] rows;
   logic [XW-1:0] x0_in, x1_in;
   logic [YW-1:0] y0_in, y1_in;

   always_comb begin
      logic [DCW-1:0] cw;
      logic [DRW-1:0] rw;
      logic [KCW-1:0] ixk, ix1k, climk;
      logic [KRW-1:0] iyk, iy1k, rlimk;
      cw = DCW'(cfg.source_cols);
      rw = DRW'(cfg.source_rows);
      // zero counts as one, anything above the maximum counts as the maximum
      if (cw == '0) begin
         cw = DCW'(1);
      end else if (cw > DCW'(MAX_COLS)) begin
         cw = DCW'(MAX_COLS);
      end
      if (rw == '0) begin
         rw = DRW'(1);
      end else if (rw > DRW'(MAX_ROWS)) begin
         rw = DRW'(MAX_ROWS);
      end
      cols = CW'(cw);
      rows = RW'(rw);

      ixk   = KCW'(req_item.src_x[rpr_pkg::COORD_W-1:FRAC_BITS]);
      ix1k  = ixk + KCW'(1);
      climk = KCW'(cols) - KCW'(1);
      iyk   = KRW'(req_item.src_y[rpr_pkg::COORD_W-1:FRAC_BITS]);
      iy1k  = iyk + KRW'(1);
      rlimk = KRW'(rows) - KRW'(1);

      x0_in = XW'((ixk < climk) ? ixk : climk);
      x1_in = XW'((ix1k < climk) ? ix1k : climk);
      y0_in = YW'((iyk < rlimk) ? iyk : rlimk);
      y1_in = YW'((iy1k < rlimk) ? iy1k : rlimk);
   end

   // stage 1
   rpr_pkg::rpr_ctl_type              s1_ctl_ff;
   logic [XW-1:0]                     s1_x0_ff, s1_x1_ff;
   logic [YW-1:0]                     s1_y0_ff, s1_y1_ff;
   logic [FRAC_BITS-1:0]              s1_fx_ff, s1_fy_ff;
   logic [rpr_pkg::STORE_AW-1:0]      s1_load_addr_ff;
   logic [rpr_pkg::PIX_W-1:0]         s1_load_value_ff;
   logic [rpr_pkg::DEST_W-1:0]        s1_dprod_ff;
   logic [rpr_pkg::COORD_W-1:0]       s1_dx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff.valid  <= req_fire;
         s1_ctl_ff.sample <= req_item.mode == rpr_pkg::MODE_SAMPLE;
      end
      s1_x0_ff         <= x0_in;
      s1_x1_ff         <= x1_in;
      s1_y0_ff         <= y0_in;
      s1_y1_ff         <= y1_in;
      s1_fx_ff         <= req_item.src_x[FRAC_BITS-1:0];
      s1_fy_ff         <= req_item.src_y[FRAC_BITS-1:0];
      s1_load_addr_ff  <= req_item.load_addr;
      s1_load_value_ff <= req_item.load_value;
      s1_dprod_ff      <= req_item.dest_y * cfg.dest_cols;
      s1_dx_ff         <= req_item.dest_x;
   end

   // stage 2: row bases, corner weights, destination address
   rpr_pkg::rpr_ctl_type                s2_ctl_ff;
   logic [PW-1:0]                       s2_row0_ff, s2_row1_ff;
   logic [XW-1:0]                       s2_x0_ff, s2_x1_ff;
   logic [rpr_pkg::STORE_AW-1:0]        s2_load_addr_ff;
   logic [rpr_pkg::PIX_W-1:0]           s2_load_value_ff;
   logic [rpr_pkg::CORNERS-1:0][WW-1:0] s2_weight_ff;
   logic [rpr_pkg::DEST_W-1:0]          s2_dest_ff;
   logic [FRAC_BITS:0]                  gx, gy, fxe, fye;

   assign fxe = {1'b0, s1_fx_ff};
   assign fye = {1'b0, s1_fy_ff};
   assign gx  = ONE_UNIT - fxe;
   assign gy  = ONE_UNIT - fye;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s1_ctl_ff;
      end
      s2_row0_ff       <= PW'(s1_y0_ff) * PW'(cols);
      s2_row1_ff       <= PW'(s1_y1_ff) * PW'(cols);
      s2_x0_ff         <= s1_x0_ff;
      s2_x1_ff         <= s1_x1_ff;
      s2_load_addr_ff  <= s1_load_addr_ff;
      s2_load_value_ff <= s1_load_value_ff;
      s2_weight_ff[0]  <= gx * gy;
      s2_weight_ff[1]  <= fxe * gy;
      s2_weight_ff[2]  <= gx * fye;
      s2_weight_ff[3]  <= fxe * fye;
      s2_dest_ff       <= s1_dprod_ff + rpr_pkg::DEST_W'(s1_dx_ff);
   end

   logic [SW-1:0] a00, a10, a01, a11;

   // addresses wrap modulo the store depth
   assign a00 = SW'(s2_row0_ff) + SW'(s2_x0_ff);
   assign a10 = SW'(s2_row0_ff) + SW'(s2_x1_ff);
   assign a01 = SW'(s2_row1_ff) + SW'(s2_x0_ff);
   assign a11 = SW'(s2_row1_ff) + SW'(s2_x1_ff);

   assign rd_addr[0] = rpr_pkg::STORE_AW'(a00);
   assign rd_addr[1] = rpr_pkg::STORE_AW'(a10);
   assign rd_addr[2] = rpr_pkg::STORE_AW'(a01);
   assign rd_addr[3] = rpr_pkg::STORE_AW'(a11);

   assign wr_en     = s2_ctl_ff.valid & ~s2_ctl_ff.sample;
   assign wr_addr   = s2_load_addr_ff;
   assign wr_data   = s2_load_value_ff;
   assign s2_ctl    = s2_ctl_ff;
   assign weight    = s2_weight_ff;
   assign dest_addr = s2_dest_ff;

endmodule

// ----- rtl/core/rpr_blend.sv -----
// Corner weighting, sum and method select for the resampled pixel.
`timescale 1ns / 1ps

module rpr_blend #(
   parameter int PIXEL_BITS = 8,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          method,
   input  rpr_pkg::rpr_ctl_type                          s2_ctl,
   input  logic [rpr_pkg::CORNERS-1:0][2*FRAC_BITS+1:0]  weight,
   input  logic [rpr_pkg::DEST_W-1:0]                    dest_addr,
   input  logic [rpr_pkg::CORNERS-1:0][PIXEL_BITS-1:0]   rd_data,
   output logic                                          rsp_push,
   output rpr_pkg::rpr_rsp_type                          rsp_item
);

   localparam int WW   = 2 * FRAC_BITS + 2;
   localparam int PRW  = PIXEL_BITS + WW;
   localparam int SUMW = PRW + 2;

   // stage 3: line up with the registered store read
   rpr_pkg::rpr_ctl_type                s3_ctl_ff;
   logic [rpr_pkg::CORNERS-1:0][WW-1:0] s3_weight_ff;
   logic [rpr_pkg::DEST_W-1:0]          s3_dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s2_ctl;
      end
      s3_weight_ff <= weight;
      s3_dest_ff   <= dest_addr;
   end

   // stage 4: one product per corner
   rpr_pkg::rpr_ctl_type                 s4_ctl_ff;
   logic [rpr_pkg::CORNERS-1:0][PRW-1:0] s4_prod_ff;
   logic [PIXEL_BITS-1:0]                s4_near_ff;
   logic [rpr_pkg::DEST_W-1:0]           s4_dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else begin
         s4_ctl_ff <= s3_ctl_ff;
      end
      for (int i = 0; i < rpr_pkg::CORNERS; i++) begin
         s4_prod_ff[i] <= rd_data[i] * s3_weight_ff[i];
      end
      s4_near_ff <= rd_data[0];
      s4_dest_ff <= s3_dest_ff;
   end

   logic [SUMW-1:0]       sum;
   logic [PIXEL_BITS-1:0] blend_val, pix;

   // weights add to one unit squared, so the shifted sum fits a pixel
   assign sum = SUMW'(s4_prod_ff[0]) + SUMW'(s4_prod_ff[1])
              + SUMW'(s4_prod_ff[2]) + SUMW'(s4_prod_ff[3]);
   assign blend_val = PIXEL_BITS'(sum >> (2 * FRAC_BITS));
   assign pix = (method == rpr_pkg::METHOD_NEAREST) ? s4_near_ff : blend_val;

   assign rsp_push             = s4_ctl_ff.valid & s4_ctl_ff.sample;
   assign rsp_item.dest_addr   = s4_dest_ff;
   assign rsp_item.pixel_value = rpr_pkg::PIX_W'(pix);

endmodule

// ----- rtl/core/rpr_rsp_fifo.sv -----
// Result queue that parts the pipeline from the result channel.
`timescale 1ns / 1ps

module rpr_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rpr_pkg::rpr_rsp_type push_item,
   input  logic                 pop,
   output logic                 out_valid,
   output rpr_pkg::rpr_rsp_type out_item
);

   localparam int PTR_W = $clog2(rpr_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(rpr_pkg::RSP_DEPTH + 1);

   rpr_pkg::rpr_rsp_type mem_ff [rpr_pkg::RSP_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // pointers wrap on their own since the depth is a power of two
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/raster_pixel_resampler_core.sv -----
// Raster pixel resampler top level: config registers, store copies, pipeline.
// Takes one item per cycle while req_stall is low.
// Each bilinear corner reads its own copy of the source store, so all four corners
// come out of the registered store read together; load items write every copy.
// Up to 8 sample items are outstanding (pipeline plus 8-entry result queue).
// Synchronous reset clears control state and loads the register defaults; store undefined.
`timescale 1ns / 1ps

module raster_pixel_resampler_core #(
   parameter int PIXEL_BITS = 8,
   parameter int MAX_COLS   = 256,
   parameter int MAX_ROWS   = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rpr_pkg::rpr_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rpr_pkg::rpr_rsp_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rpr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpr_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CNT_W = $clog2(rpr_pkg::RSP_DEPTH + 1);
   localparam int AW    = rpr_pkg::STORE_AW;
   localparam int WW    = 2 * FRAC_BITS + 2;

   // configuration registers
   rpr_pkg::rpr_cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rpr_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (rpr_pkg::rpr_csr_index_type'(csr_index))
            rpr_pkg::CSR_METHOD:      cfg_ff.method      <= csr_data[0];
            rpr_pkg::CSR_SOURCE_COLS: cfg_ff.source_cols <= csr_data[rpr_pkg::CFG_DIM_W-1:0];
            rpr_pkg::CSR_SOURCE_ROWS: cfg_ff.source_rows <= csr_data[rpr_pkg::CFG_DIM_W-1:0];
            rpr_pkg::CSR_DEST_COLS:   cfg_ff.dest_cols   <= csr_data;
            default: ;
         endcase
      end
   end

   // outstanding sample items; hold input once the result queue could overflow
   logic             req_fire, sample_fire, rsp_fire;
   logic [CNT_W-1:0] inflight_ff, inflight_in;

   assign req_fire    = req_valid & ~req_stall;
   assign sample_fire = req_fire & (req_data.mode == rpr_pkg::MODE_SAMPLE);
   assign rsp_fire    = rsp_valid & ~rsp_stall;
   assign req_stall   = inflight_ff == CNT_W'(rpr_pkg::RSP_DEPTH);

   always_comb begin
      inflight_in = inflight_ff;
      case ({sample_fire, rsp_fire})
         2'b10:   inflight_in = inflight_ff + CNT_W'(1);
         2'b01:   inflight_in = inflight_ff - CNT_W'(1);
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   rpr_pkg::rpr_ctl_type                         s2_ctl;
   logic [rpr_pkg::CORNERS-1:0][WW-1:0]          weight;
   logic [rpr_pkg::DEST_W-1:0]                   dest_addr;
   logic                                         wr_en;
   logic [AW-1:0]                                wr_addr;
   logic [rpr_pkg::PIX_W-1:0]                    wr_data;
   logic [rpr_pkg::CORNERS-1:0][AW-1:0]          rd_addr;
   logic [rpr_pkg::CORNERS-1:0][PIXEL_BITS-1:0]  rd_data;
   logic                                         rsp_push;
   rpr_pkg::rpr_rsp_type                         rsp_item;

   rpr_fetch #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .FRAC_BITS (FRAC_BITS)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_item  (req_data),
      .cfg       (cfg_ff),
      .s2_ctl    (s2_ctl),
      .weight    (weight),
      .dest_addr (dest_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr)
   );

   for (genvar i = 0; i < rpr_pkg::CORNERS; i++) begin : g_store
      rpr_ram #(
         .WIDTH (PIXEL_BITS),
         .DEPTH (rpr_pkg::STORE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (PIXEL_BITS'(wr_data)),
         .rd_addr (rd_addr[i]),
         .rd_data (rd_data[i])
      );
   end

   rpr_blend #(
      .PIXEL_BITS (PIXEL_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .method    (cfg_ff.method),
      .s2_ctl    (s2_ctl),
      .weight    (weight),
      .dest_addr (dest_addr),
      .rd_data   (rd_data),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   rpr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_item),
      .pop       (rsp_fire),
      .out_valid (rsp_valid),
      .out_item  (rsp_data)
   );

endmodule

// ----- rtl/core/rpr_checker.sv -----
// Port-level assertions for the resampler core, bound to the top level.
`timescale 1ns / 1ps

module rpr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input rpr_pkg::rpr_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rpr_pkg::rpr_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(rpr_pkg::RSP_DEPTH + 2);

   logic             sample_fire, rsp_fire;
   logic [CNT_W-1:0] owed_ff;

   assign sample_fire = req_valid & ~req_stall & (req_data.mode == rpr_pkg::MODE_SAMPLE);
   assign rsp_fire    = rsp_valid & ~rsp_stall;

   // count sample items still owed a result
   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else if (sample_fire && !rsp_fire) begin
         owed_ff <= owed_ff + CNT_W'(1);
      end else if (rsp_fire && !sample_fire) begin
         owed_ff <= owed_ff - CNT_W'(1);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != '0)
      else $error("result item offered with no sample item owed");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> owed_ff == CNT_W'(rpr_pkg::RSP_DEPTH))
      else $error("input stalled below the outstanding limit");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      sample_fire && owed_ff == '0 |-> ##5 rsp_valid)
      else $error("sample item result late on an empty pipeline");

endmodule

bind raster_pixel_resampler_core rpr_checker u_checker (.*);
